FILE: src/assert_macros.svh
// Assertion macros used by the click classifier core, bcc_core.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: src/bcc_pkg.sv
// Shared types, constants and helpers for the button click classifier.
// No dependencies; used by bcc_core and button_click_classifier.
package bcc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned WinWidth   = 16;
  localparam int unsigned CmpWidth   = (CountWidth > WinWidth) ? CountWidth : WinWidth;

  localparam logic [WinWidth-1:0] WindowReset = WinWidth'(50);
  localparam logic [1:0]          TallyMax    = 2'd3;
  localparam logic [1:0]          TallyOne    = 2'd1;
  localparam logic [1:0]          TallyTwo    = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } click_event_e;

  typedef struct packed {
    logic                  press_seen;
    logic                  edge_taken;
    logic [1:0]            press_tally;
    logic [CountWidth-1:0] wait_ticks;
    logic [CountWidth-1:0] hold_ticks;
  } click_state_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (&v) ? v : v + CountWidth'(1);
  endfunction

endpackage

FILE: src/button_click_classifier.sv
// Top level of the button click classifier: input register, result register, window.
// Depends on bcc_pkg and bcc_core.
//
// Each accepted transaction carries one sampled button level (0 pressed) and yields
// exactly one result transaction: 0 no event, 1 single click, 2 double click. An item
// passes an input register and the classification logic into a result register. One
// item per cycle is sustained while the result side keeps taking, and a waiting result
// stalls the input side only once the input register is also full. The window register
// resets to 50 ticks and may be written whenever no item is in flight; the write
// channel is always ready.

module button_click_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [0] key_level, [7:1] zero
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [1:0] click_event, [7:2] zero
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic                         in_valid_q, in_valid_d;
  logic                         in_key_q;
  logic                         out_valid_q, out_valid_d;
  bcc_pkg::click_event_e        out_event_q;
  logic [bcc_pkg::WinWidth-1:0] window_q;

  logic                  stall;
  logic                  advance;
  logic                  s_take;
  bcc_pkg::click_event_e core_event;

  assign stall   = out_valid_q & ~m_axis_tready_i;
  assign advance = in_valid_q & ~stall;
  assign s_axis_tready_o = ~(in_valid_q & stall);
  assign s_take  = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (s_take) begin
      in_valid_d = 1'b1;
    end
    if (!stall) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= bcc_pkg::WindowReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        window_q <= cfg_data_i;
      end
    end
  end

  // Payload registers: in_key_q loads on s_take, out_event_q on advance.
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_key_q <= s_axis_tdata_i[0];
    end
    if (advance) begin
      out_event_q <= core_event;
    end
  end

  bcc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .key_level_i(in_key_q),
    .window_i   (window_q),
    .event_o    (core_event)
  );

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_event_q};

endmodule

FILE: src/bcc_core.sv
// Per-tick click classification: state registers plus the next-state logic.
// Depends on bcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcc_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         key_level_i,
  input  logic [bcc_pkg::WinWidth-1:0] window_i,
  output bcc_pkg::click_event_e        event_o
);

  bcc_pkg::click_state_t st_q, st_d;

  logic                           released;
  logic                           ps_set;
  logic                           done;
  logic [bcc_pkg::CountWidth-1:0] hold_n;
  logic [bcc_pkg::CountWidth-1:0] wait_inc;
  logic [bcc_pkg::CmpWidth-1:0]   win_x;
  logic [bcc_pkg::CmpWidth-1:0]   wait_x;
  logic [bcc_pkg::CmpWidth-1:0]   hold_x;
  bcc_pkg::click_event_e          ev;

  always_comb begin
    released = key_level_i;
    hold_n   = released ? '0 : bcc_pkg::sat_inc(st_q.hold_ticks);
    ps_set   = st_q.press_seen | ~released;
    wait_inc = bcc_pkg::sat_inc(st_q.wait_ticks);
    win_x    = bcc_pkg::CmpWidth'(window_i);
    wait_x   = bcc_pkg::CmpWidth'(wait_inc);
    hold_x   = bcc_pkg::CmpWidth'(hold_n);

    st_d            = st_q;
    st_d.hold_ticks = hold_n;
    st_d.press_seen = ps_set;
    ev              = bcc_pkg::EV_NONE;
    done            = 1'b0;

    // Tally a fresh press edge; the second one is a double click.
    if (!st_q.edge_taken) begin
      if (ps_set) begin
        if (st_d.press_tally != bcc_pkg::TallyMax) begin
          st_d.press_tally = st_d.press_tally + 2'd1;
        end
        st_d.edge_taken = 1'b1;
      end
      if (st_d.press_tally == bcc_pkg::TallyTwo) begin
        st_d.press_tally = '0;
        st_d.wait_ticks  = '0;
        ev               = bcc_pkg::EV_DOUBLE;
        done             = 1'b1;
      end
    end

    if (!done) begin
      if (released) begin
        st_d.press_seen = 1'b0;
        st_d.edge_taken = 1'b0;
      end
      if (st_d.press_tally == bcc_pkg::TallyOne) begin
        if (wait_x > win_x && hold_x < win_x) begin
          st_d.press_tally = '0;
          st_d.wait_ticks  = '0;
          ev               = bcc_pkg::EV_SINGLE;
        end else if (hold_x > win_x) begin
          // Long hold: drop the pending click silently.
          st_d.press_tally = '0;
          st_d.wait_ticks  = '0;
        end else begin
          st_d.wait_ticks = wait_inc;
        end
      end
    end
  end

  assign event_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  `ASSERT_ALWAYS(a_tally_low, st_q.press_tally == 2'd0 || st_q.press_tally == bcc_pkg::TallyOne, "press tally left its reachable range")
  `ASSERT_ALWAYS(a_wait_needs_tally, st_q.wait_ticks == '0 || st_q.press_tally == bcc_pkg::TallyOne, "wait counter running with no pending press")
  `ASSERT_ALWAYS(a_hold_needs_press, st_q.hold_ticks == '0 || st_q.press_seen, "hold counter running without a noted press")
  `ASSERT_NEXT(a_double_clears, en_i && ev == bcc_pkg::EV_DOUBLE, st_q.press_tally == '0 && st_q.wait_ticks == '0, "double click did not clear the sequence")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_click_classifier: directed and random key-level streams.
// Depends on bcc_pkg (click_event_e, tally and window constants) and the button_click_classifier RTL.

module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;    // [0] key_level, [7:1] zero
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;            // [1:0] click_event, [7:2] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  // Behavioral copy of the classifier state
  logic [15:0] click_window;
  logic        key_down;
  logic        press_counted;
  logic [1:0]  presses;
  logic [15:0] wait_count;
  logic [15:0] hold_count;

  bcc_pkg::click_event_e expected_events[$];
  int                    mismatch_count = 0;
  bit                    stall_off = 1'b0;

  button_click_classifier u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  initial begin
    #20_000_000;
    $display("** button_click_classifier: FAILED **");
    $finish;
  end

  function automatic logic [15:0] count_up(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // One scan tick of the classifier; updates the model state and returns the event.
  function automatic bcc_pkg::click_event_e classify_tick(logic released);
    hold_count = released ? 16'd0 : count_up(hold_count);
    if (!released) key_down = 1'b1;
    if (!press_counted) begin
      if (key_down) begin
        if (presses != bcc_pkg::TallyMax) presses = presses + 2'd1;
        press_counted = 1'b1;
      end
      if (presses == bcc_pkg::TallyTwo) begin
        presses    = 2'd0;
        wait_count = 16'd0;
        return bcc_pkg::EV_DOUBLE;
      end
    end
    if (released) begin
      key_down      = 1'b0;
      press_counted = 1'b0;
    end
    if (presses == bcc_pkg::TallyOne) begin
      wait_count = count_up(wait_count);
      if (wait_count > click_window && hold_count < click_window) begin
        presses    = 2'd0;
        wait_count = 16'd0;
        return bcc_pkg::EV_SINGLE;
      end
      // a hold past the window drops the pending click silently
      if (hold_count > click_window) begin
        presses    = 2'd0;
        wait_count = 16'd0;
      end
    end
    return bcc_pkg::EV_NONE;
  endfunction

  task automatic send_level(logic level);
    int gap;
    gap = stall_off ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {7'b0, level};
    do @(negedge clk_i); while (!s_ready);
    @(posedge clk_i);
    expected_events.push_back(classify_tick(level));
  endtask

  task automatic press_for(int n);
    repeat (n) send_level(1'b0);
  endtask

  task automatic release_for(int n);
    repeat (n) send_level(1'b1);
  endtask

  // Hold the input side until every outstanding result has been taken.
  task automatic wait_all_results();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (expected_events.size() != 0);
  endtask

  task automatic set_window(logic [15:0] w);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    cfg_valid    <= 1'b0;
    click_window = w;
  endtask

  // Reset window of 50: a short press followed by a long release.
  task automatic test_reset_window();
    press_for(2);
    release_for(52);
  endtask

  task automatic test_double_click();
    set_window(16'd4);
    press_for(1);
    release_for(2);
    press_for(2);
    release_for(6);
  endtask

  // Hold exactly the window still yields a single click; one more tick cancels.
  task automatic test_hold_threshold();
    set_window(16'd3);
    press_for(3);
    release_for(3);
    press_for(4);
    release_for(5);
  endtask

  task automatic test_zero_window();
    set_window(16'd0);
    release_for(2);
    press_for(1);
    release_for(2);
    press_for(2);
    release_for(1);
  endtask

  // Widest window: a long press then a quick second press, back-to-back transactions.
  task automatic test_saturation();
    set_window(16'hFFFF);
    stall_off = 1'b1;
    press_for(40);
    release_for(4);
    press_for(1);
    release_for(2);
    stall_off = 1'b0;
  endtask

  task automatic test_drain_pause();
    set_window(16'd3);
    press_for(1);
    release_for(1);
    wait_all_results();
    press_for(1);
    release_for(5);
    press_for(2);
    wait_all_results();
    release_for(5);
  endtask

  task automatic test_random(int n_items);
    int sent;
    int k;
    int run;
    int cap;
    int phase_len;
    logic [15:0] w;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0:       w = 16'hFFFF;
        1:       w = 16'($urandom_range(0, 16'hFFFF));
        2:       w = 16'd0;
        default: w = 16'($urandom_range(1, 10));
      endcase
      set_window(w);
      stall_off = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 140);
      cap = (w > 20) ? 20 : int'(w);
      k = 0;
      while (k < phase_len) begin
        if ($urandom_range(0, 99) < 85) begin
          run = $urandom_range(1, cap + 2);
          press_for(run);
          k += run;
          run = $urandom_range(1, 2 * cap + 3);
          release_for(run);
          k += run;
        end else begin
          send_level(1'($urandom_range(0, 1)));
          k++;
        end
      end
      sent += k;
    end
    stall_off = 1'b0;
  endtask

  initial begin : result_checker
    int stall;
    logic [1:0] got;
    bcc_pkg::click_event_e want;
    @(posedge rst_ni);
    forever begin
      stall = stall_off ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(negedge clk_i); while (!m_valid);
      got = m_data[1:0];
      @(posedge clk_i);
      if (expected_events.size() == 0) begin
        $error("click_event: expected none, got %0d", got);
        mismatch_count++;
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          $error("click_event: expected %0d, got %0d", want, got);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    click_window  = bcc_pkg::WindowReset;
    key_down      = 1'b0;
    press_counted = 1'b0;
    presses       = 2'd0;
    wait_count    = 16'd0;
    hold_count    = 16'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_window();
    test_double_click();
    test_hold_threshold();
    test_zero_window();
    test_drain_pause();
    test_saturation();
    test_random(1500);
    wait_all_results();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("** button_click_classifier: PASSED **");
    end else begin
      $display("** button_click_classifier: FAILED **");
    end
    $finish;
  end

endmodule
